[hdl/hash_table_insert_remove_assert.svh]
// Assertion macros for the bucketed hash table.
`ifndef HASH_TABLE_INSERT_REMOVE_ASSERT_SVH
`define HASH_TABLE_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HTIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HTIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/htir_pkg.sv]
// Shared constants, types and helpers of the bucketed hash table.
`timescale 1ns / 1ps
package htir_pkg;

  localparam int CMD_W  = 1;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int BKT_W  = 4;
  localparam int CFG_W  = 5;
  localparam int CFG_MAX = (1 << CFG_W) - 1;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam int DEF_NUM_BUCKETS = 16;
  localparam int DEF_BUCKET_WAYS = 4;

  localparam logic [CFG_W-1:0] RESET_BUCKET_COUNT = 5'd10;

  // Word index of the bucket count register (paddr bit above the byte offset).
  localparam logic REG_BUCKET_COUNT = 1'b0;

  // Modulo unit: key bits retired per cycle and number of steps.
  localparam int MOD_BITS   = 8;
  localparam int MOD_STEPS  = (KEY_W + MOD_BITS - 1) / MOD_BITS;
  localparam int MOD_W      = MOD_STEPS * MOD_BITS;
  localparam int MOD_STEP_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_EVAL
  } htir_state_e;

  typedef struct packed {
    logic                 vld;
    logic [KEY_W-1:0]     key;
    logic [VAL_W-1:0]     value;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic mod_step;
    logic rd;
    logic commit;
  } htir_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic out_free;
  } htir_sts_t;

  // Largest bucket count that can be in use: bounded by the table and the register.
  function automatic int max_count(int num_buckets);
    return (num_buckets < CFG_MAX) ? num_buckets : CFG_MAX;
  endfunction

endpackage

[hdl/htir_if.sv]
// Valid/ready channel interfaces for operations and results.
`timescale 1ns / 1ps
interface htir_in_if import htir_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [KEY_W-1:0]        key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface htir_out_if import htir_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BKT_W-1:0]  bucket;

  modport source (output valid, output status, output bucket, input ready);
  modport sink   (input valid, input status, input bucket, output ready);
endinterface

[hdl/htir_mod.sv]
// Iterative key modulo bucket count, several remainder steps per cycle.
`timescale 1ns / 1ps
module htir_mod import htir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [CFG_W-1:0] div_i,
  output logic [CFG_W-1:0] rem_o,
  output logic             last_o
);

  logic [MOD_W-1:0]      sh_q, sh_d;
  logic [CFG_W-1:0]      rem_q, rem_d;
  logic [MOD_STEP_W-1:0] cnt_q;
  logic [CFG_W:0]        t;
  logic [CFG_W-1:0]      r;
  logic [MOD_W-1:0]      s;

  // Remainder stays below the divisor, so one conditional subtract per bit.
  always_comb begin
    r = rem_q;
    s = sh_q;
    t = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {r, s[MOD_W-1]};
      s = {s[MOD_W-2:0], 1'b0};
      if (t >= {1'b0, div_i}) begin
        t = t - {1'b0, div_i};
      end
      r = t[CFG_W-1:0];
    end
    rem_d = r;
    sh_d  = s;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= MOD_W'(key_i);
      rem_q <= '0;
    end else if (step_i) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign rem_o  = rem_q;
  assign last_o = (cnt_q == MOD_STEP_W'(MOD_STEPS - 1));

endmodule

[hdl/htir_dp.sv]
// Datapath: operand capture, modulo unit, bucket row memory, way search, result register.
`timescale 1ns / 1ps
module htir_dp import htir_pkg::*; #(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
  parameter int BUCKET_WAYS = DEF_BUCKET_WAYS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  htir_cmd_t               cmd_i,
  output htir_sts_t               sts_o,
  input  logic [CMD_W-1:0]        in_cmd_i,
  input  logic [KEY_W-1:0]        in_key_i,
  input  logic signed [VAL_W-1:0] in_value_i,
  input  logic [CFG_W-1:0]        eff_cnt_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [STAT_W-1:0]       out_status_o,
  output logic [BKT_W-1:0]        out_bucket_o
);

  localparam int MAX_CNT = max_count(NUM_BUCKETS);
  localparam int ROW_W   = (MAX_CNT > 1) ? $clog2(MAX_CNT) : 1;
  localparam int WAY_W   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

  typedef entry_t [BUCKET_WAYS-1:0] row_t;

  logic [CMD_W-1:0]  op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [CFG_W-1:0]  rem;
  logic              mod_last;
  logic [ROW_W-1:0]  idx;
  logic [ROW_W-1:0]  clr_q;
  row_t              mem_q [MAX_CNT];
  row_t              row_q, row_d;
  logic              hit_found, free_found;
  logic [WAY_W-1:0]  hit_idx, free_idx;
  status_e           status_d;
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [BKT_W-1:0]  out_bucket_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_cmd_i;
      key_q <= in_key_i;
      val_q <= in_value_i;
    end
  end

  htir_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .step_i  (cmd_i.mod_step),
    .key_i   (in_key_i),
    .div_i   (eff_cnt_i),
    .rem_o   (rem),
    .last_o  (mod_last)
  );

  assign idx = rem[ROW_W-1:0];

  // Search the bucket row: first matching valid way, first free way; then form the updated row and the status.
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (row_q[w].vld) begin
        if (!hit_found && (row_q[w].key == key_q)) begin
          hit_found = 1'b1;
          hit_idx   = WAY_W'(w);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = WAY_W'(w);
      end
    end

    row_d    = row_q;
    status_d = ST_NOT_FOUND;
    if (op_q == OP_INSERT) begin
      if (hit_found) begin
        row_d[hit_idx].value = val_q;
        status_d             = ST_REPLACED;
      end else if (free_found) begin
        row_d[free_idx].vld   = 1'b1;
        row_d[free_idx].key   = key_q;
        row_d[free_idx].value = val_q;
        status_d              = ST_INSERTED;
      end else begin
        status_d = ST_FULL;
      end
    end else begin
      if (hit_found) begin
        row_d[hit_idx].vld = 1'b0;
        status_d           = ST_REMOVED;
      end
    end
  end

  // Row memory: one write port (clear or write-back), one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.commit) begin
      mem_q[idx] <= row_d;
    end
    if (cmd_i.rd) begin
      row_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= status_d;
      out_bucket_q <= rem[BKT_W-1:0];
    end
  end

  assign sts_o.clr_last = (clr_q == ROW_W'(MAX_CNT - 1));
  assign sts_o.mod_last = mod_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_bucket_o = out_bucket_q;

endmodule

[hdl/htir_ctrl.sv]
// Controller: sequences clearing, modulo, row read and write-back.
`timescale 1ns / 1ps
module htir_ctrl import htir_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  htir_sts_t sts_i,
  output htir_cmd_t cmd_o
);

  htir_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        // hold the row until the result register can take the transfer
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/hash_table_insert_remove.sv]
// Top level of the bucketed key-value hash table with its register port.
// Operations arrive on in_i (cmd, key, value): cmd 0 inserts or replaces the
// value of key, cmd 1 removes key. Each operation gives exactly one result
// on out_o: status (inserted, replaced, removed, not found, full) and the
// bucket that the key hashed to, key modulo the bucket count register.
// The bucket count is written over the APB port at address 0; 0 acts as 1
// and values above the table's bucket count act as that count.
// Sequence: an operation is taken, the modulo unit retires eight key bits a cycle
// over its steps, then the bucket row is read and written back with the result.
// No new operation is taken until the previous one has been written back.
// The result sits in an output register: the next operation is taken while
// it waits, and only its write-back holds while the receiver stalls.
// After reset the row memory is swept once to clear all valid marks, one row
// a cycle; no operation is taken until then, while register writes are taken
// at all times.
`timescale 1ns / 1ps
`include "hash_table_insert_remove_assert.svh"
module hash_table_insert_remove import htir_pkg::*; #(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
  parameter int BUCKET_WAYS = DEF_BUCKET_WAYS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  htir_in_if.sink           in_i,
  htir_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int MAX_CNT = max_count(NUM_BUCKETS);

  logic [CFG_W-1:0] cnt_q;
  logic [CFG_W-1:0] eff_cnt;
  htir_cmd_t        cmd;
  htir_sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= RESET_BUCKET_COUNT;
    end else if (psel && penable && pwrite && (paddr[APB_AW-1] == REG_BUCKET_COUNT)) begin
      cnt_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1] == REG_BUCKET_COUNT) ? APB_DW'(cnt_q) : '0;

  always_comb begin
    if (cnt_q == '0) begin
      eff_cnt = CFG_W'(1);
    end else if (int'(cnt_q) > MAX_CNT) begin
      eff_cnt = CFG_W'(MAX_CNT);
    end else begin
      eff_cnt = cnt_q;
    end
  end

  htir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htir_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BUCKET_WAYS (BUCKET_WAYS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (in_i.cmd),
    .in_key_i     (in_i.key),
    .in_value_i   (in_i.value),
    .eff_cnt_i    (eff_cnt),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_bucket_o (out_o.bucket)
  );

  `HTIR_ASSERT_NOW(a_no_take_while_clearing, cmd.clear, !in_i.ready, "operation taken during clear sweep")
  `HTIR_ASSERT_NEXT(a_one_in_flight, in_i.valid && in_i.ready, !in_i.ready, "second operation taken while busy")
  `HTIR_ASSERT_NOW(a_bucket_in_range, out_o.valid, CFG_W'(out_o.bucket) < eff_cnt, "bucket not below bucket count")

endmodule

[bench/hash_table_insert_remove_test.sv]
// Self-checking testbench for the bucketed key-value hash table.
`timescale 1ns / 1ps
module hash_table_insert_remove_test import htir_pkg::*;;

  localparam int NUM_BUCKETS    = DEF_NUM_BUCKETS;
  localparam int WAYS           = DEF_BUCKET_WAYS;
  localparam int NUM_SLOTS      = NUM_BUCKETS * WAYS;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 160;
  localparam int POOL_SIZE      = 20;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    status_e          status;
    logic [BKT_W-1:0] bucket;
  } outcome_t;

  typedef enum int unsigned {
    PACE_OPEN,
    PACE_COIN,
    PACE_SPARSE,
    PACE_PERIODIC
  } pace_e;

  // Table predictor and store of expected outcomes, oldest first.
  class kv_table_sb;
    bit               slot_vld [NUM_SLOTS];
    logic [KEY_W-1:0] slot_key [NUM_SLOTS];
    logic [VAL_W-1:0] slot_val [NUM_SLOTS];
    logic [CFG_W-1:0] count_reg;
    outcome_t         outcome_q [$];
    int unsigned      errors;

    function new();
      count_reg = RESET_BUCKET_COUNT;
      errors = 0;
      foreach (slot_vld[i]) slot_vld[i] = 1'b0;
    endfunction

    function void set_count(logic [CFG_W-1:0] count);
      count_reg = count;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    function void apply_op(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      int unsigned n;
      int unsigned bkt;
      int          base;
      int          hit;
      int          free_way;
      outcome_t    o;
      n = 32'(count_reg);
      if (n == 0) n = 1;
      if (n > NUM_BUCKETS) n = NUM_BUCKETS;
      bkt = key % n;
      base = bkt * WAYS;
      hit = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (slot_vld[base + w]) begin
          if (hit < 0 && slot_key[base + w] == key) hit = w;
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      if (op == OP_INSERT) begin
        if (hit >= 0) begin
          slot_val[base + hit] = value;
          o.status = ST_REPLACED;
        end else if (free_way >= 0) begin
          slot_vld[base + free_way] = 1'b1;
          slot_key[base + free_way] = key;
          slot_val[base + free_way] = value;
          o.status = ST_INSERTED;
        end else begin
          o.status = ST_FULL;
        end
      end else begin
        if (hit >= 0) begin
          slot_vld[base + hit] = 1'b0;
          o.status = ST_REMOVED;
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
      o.bucket = bkt[BKT_W-1:0];
      outcome_q.push_back(o);
    endfunction

    function void check_outcome(logic [STAT_W-1:0] status, logic [BKT_W-1:0] bucket);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d bucket %0d", $time, status, bucket);
        return;
      end
      o = outcome_q.pop_front();
      if (o.status != status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, o.status, status);
      end
      if (o.bucket != bucket) begin
        errors++;
        $display("%0t: bucket mismatch: expected %0d actual %0d", $time, o.bucket, bucket);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  htir_in_if  op_if ();
  htir_out_if res_if ();

  kv_table_sb       sb = new();
  bit               hold_req = 1'b0;
  int unsigned      burst_left = 0;
  int unsigned      idle_cycles = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  hash_table_insert_remove #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .BUCKET_WAYS(WAYS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  // Offer one operation and hold it until the transfer; valid stays high after.
  task automatic send_op(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    op_if.valid <= 1'b1;
    op_if.cmd   <= op;
    op_if.key   <= key;
    op_if.value <= value;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
    sb.apply_op(op, key, value);
  endtask

  task automatic paced_op(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        op_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_op(op, key, value);
  endtask

  // Drain all outstanding results, then write the bucket count register.
  task automatic set_bucket_count(logic [CFG_W-1:0] count);
    logic [APB_DW-1:0] junk;
    junk = $urandom;
    op_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BUCKET_COUNT, 2'b00};
    pwdata  <= {junk[APB_DW-1:CFG_W], count};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_count(count);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] count;
    logic [KEY_W-1:0] key;
    op_e              op;
    op_if.valid <= 1'b0;
    op_if.cmd   <= OP_INSERT;
    op_if.key   <= '0;
    op_if.value <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset bucket count: key extremes, replace, full bucket, absent remove.
    send_op(OP_INSERT, 31'd0, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 31'h7FFF_FFFF, 32'h8000_0000);
    send_op(OP_INSERT, 31'd0, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 31'd3, 32'h0000_0000);
    send_op(OP_INSERT, 31'd13, 32'h5555_5555);
    send_op(OP_INSERT, 31'd23, 32'hAAAA_AAAA);
    send_op(OP_INSERT, 31'd33, 32'h0000_0001);
    send_op(OP_INSERT, 31'd43, 32'h1234_5678);
    send_op(OP_REMOVE, 31'd23, $urandom);
    send_op(OP_REMOVE, 31'd23, $urandom);
    send_op(OP_INSERT, 31'd43, 32'h8765_4321);
    send_op(OP_REMOVE, 31'h7FFF_FFFF, $urandom);
    send_op(OP_REMOVE, 31'd5, $urandom);

    // Zero count acts as one; entries placed earlier stay in their old bucket.
    set_bucket_count(5'd0);
    send_op(OP_INSERT, 31'h5555_5555, 32'hDEAD_BEEF);
    send_op(OP_REMOVE, 31'd3, $urandom);
    send_op(OP_REMOVE, 31'd0, $urandom);

    // Count above the table size clamps to the table size; then counts of 16 and 1.
    set_bucket_count(5'd31);
    send_op(OP_INSERT, 31'h2AAA_AAAA, 32'h0F0F_0F0F);
    send_op(OP_INSERT, 31'd15, 32'hF0F0_F0F0);
    send_op(OP_INSERT, 31'd13, 32'h7FFF_FFFE);
    set_bucket_count(5'd16);
    send_op(OP_REMOVE, 31'd15, $urandom);
    set_bucket_count(5'd1);
    send_op(OP_INSERT, 31'h7FFF_FFFF, 32'h8000_0001);
    send_op(OP_INSERT, 31'h5555_5555, 32'h0000_0002);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: count = 5'd10;
        1: count = 5'd1;
        2: count = 5'd0;
        3: count = 5'd31;
        4: count = 5'd16;
        5: count = 5'd2;
        6: count = 5'd17;
        7: count = 5'd7;
        default: count = CFG_W'($urandom_range(0, CFG_MAX));
      endcase
      set_bucket_count(count);
      // Mostly reuse a small key set so hits, replaces and full buckets happen.
      for (int j = 0; j < POOL_SIZE; j++) begin
        key_pool[j] = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 63))
                                           : KEY_W'($urandom);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == 30) hold_req = 1'b1;
        if ($urandom_range(0, 99) < 75) begin
          key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          key = KEY_W'($urandom);
        end
        op = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_REMOVE;
        paced_op(op, key, $urandom);
      end
    end

    op_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side stalls on its own pattern, with one long hold-off on request.
  initial begin : result_pacer
    int unsigned seg_left;
    int unsigned hold_left;
    int unsigned period;
    int unsigned tick;
    bit          hold_taken;
    pace_e       mode;
    res_if.ready <= 1'b0;
    seg_left = 0;
    hold_left = 0;
    period = 2;
    tick = 0;
    hold_taken = 1'b0;
    mode = PACE_OPEN;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          mode = pace_e'($urandom_range(0, 3));
          period = $urandom_range(2, 9);
        end
        seg_left--;
        tick++;
        case (mode)
          PACE_OPEN:   res_if.ready <= 1'b1;
          PACE_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:     res_if.ready <= (tick % period == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_outcome(res_if.status, res_if.bucket);
    end
  end

  // Stop a hung run: count cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
